FILE: rtl/gmps_pkg.sv
// ----------------------------------------------------------------------------
// gmps_pkg: shared definitions for the grid maze path search
// Move codes, configuration register indexes, port widths and the command
// bundle that drives the search stack memory.
// ----------------------------------------------------------------------------
`default_nettype none

package gmps_pkg;

  // Port widths fixed by the item format
  localparam int FIELD_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  // Move codes, tried in this order; MOVE_DONE means all four are used up
  localparam int MOVE_W = 3;
  localparam logic [MOVE_W-1:0] MOVE_DOWN  = 3'd0;
  localparam logic [MOVE_W-1:0] MOVE_RIGHT = 3'd1;
  localparam logic [MOVE_W-1:0] MOVE_LEFT  = 3'd2;
  localparam logic [MOVE_W-1:0] MOVE_UP    = 3'd3;
  localparam logic [MOVE_W-1:0] MOVE_DONE  = 3'd4;

  // Stack memory command bundle
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } stk_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/gmps_stack.sv
// ----------------------------------------------------------------------------
// gmps_stack: backtracking stack memory
// Holds row, column and next move for every search level below the top.
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gmps_stack #(
  parameter int ROW_W = 4,
  parameter int COL_W = 4,
  parameter int DEPTH = 256,
  parameter int ADDR_W = 8
) (
  input  wire                         clk,
  input  gmps_pkg::stk_cmd_t          cmd,
  input  wire  [ADDR_W-1:0]           wr_addr,
  input  wire  [ROW_W-1:0]            wr_row,
  input  wire  [COL_W-1:0]            wr_col,
  input  wire  [gmps_pkg::MOVE_W-1:0] wr_move,
  input  wire  [ADDR_W-1:0]           rd_addr,
  output logic [ROW_W-1:0]            rd_row,
  output logic [COL_W-1:0]            rd_col,
  output logic [gmps_pkg::MOVE_W-1:0] rd_move
);

  localparam int DATA_W = ROW_W + COL_W + gmps_pkg::MOVE_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;

  // Write one level
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= {wr_row, wr_col, wr_move};
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign {rd_row, rd_col, rd_move} = rd_data;

endmodule

`default_nettype wire

FILE: rtl/grid_maze_path_search_top.sv
// ----------------------------------------------------------------------------
// grid_maze_path_search_top: maze loader, backtracking path search, answer out
// Loads a maze one row at a time, searches all simple paths from the top-left
// to the bottom-right cell depth first, keeps the last path found and sends
// it out one row per transfer.
// ----------------------------------------------------------------------------
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+-----------
//  input   | in_valid, in_ready, row_walls          | in
//  output  | out_valid, out_ready, path_row, last_row | out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
//  A row that does not complete the maze is stored and the input stays ready.
//  The completing row starts the search: each move is tried in the search state,
//  a step back passes through the reload state for the stack memory read, and a
//  path found goes through the target check and the answer copy. The search time
//  is data dependent and set by the single neighbor check unit and the stack
//  memory with its registered read.
//  Afterwards rows output transfers follow at up to one per cycle; the input
//  is ready only while no search or output run is in progress.
//  Reset is synchronous: it clears the visit marks, counters and state, and
//  sets rows and cols to their maximum of 16. Output stalls hold the run.
//
`default_nettype none

module grid_maze_path_search_top #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  wire                             clk,
  input  wire                             rst,
  // input rows
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire  [gmps_pkg::FIELD_W-1:0]    row_walls,
  // answer rows
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [gmps_pkg::FIELD_W-1:0]    path_row,
  output logic                            last_row,
  // configuration
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [gmps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [gmps_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NRW    = RW + 1;
  localparam int NCW    = CW + 1;
  localparam int STK_N  = MAX_ROWS * MAX_COLS;
  localparam int SAW    = (STK_N > 1) ? $clog2(STK_N) : 1;
  localparam int DEP_W  = $clog2(STK_N + 1) + 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_COPY   = 3'd2;
  localparam logic [2:0] ST_POPLD  = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  logic [2:0] state;

  logic [gmps_pkg::CFG_DATA_W-1:0] rows_cfg;
  logic [gmps_pkg::CFG_DATA_W-1:0] cols_cfg;
  logic [NRW-1:0] nr;
  logic [NCW-1:0] nc;

  logic [MAX_COLS-1:0] wall_rows   [MAX_ROWS];
  logic [MAX_COLS-1:0] visit_rows  [MAX_ROWS];
  logic [MAX_COLS-1:0] answer_rows [MAX_ROWS];

  logic [NRW-1:0] load_cnt;
  logic [NRW-1:0] load_idx;
  logic [NRW-1:0] load_inc;
  logic           load_done;
  logic           in_xfer;

  logic [RW-1:0]  cur_r;
  logic [CW-1:0]  cur_c;
  logic [gmps_pkg::MOVE_W-1:0] cur_mv;
  logic [DEP_W-1:0] depth;
  logic [DEP_W-1:0] depth_m1;
  logic [DEP_W-1:0] depth_m2;
  logic           found;
  logic [RW-1:0]  copy_idx;
  logic [RW-1:0]  out_idx;

  logic [RW-1:0]  nb_r;
  logic [CW-1:0]  nb_c;
  logic           nb_ok;
  logic [RW-1:0]  visit_addr;
  logic [MAX_COLS-1:0] visit_rd;
  logic [MAX_COLS-1:0] wall_rd;
  logic           blocked;
  logic           at_target;
  logic           push;
  logic           pop;
  logic           pop_last;
  logic [MAX_COLS-1:0] colmask;

  gmps_pkg::stk_cmd_t stk_cmd;
  logic [RW-1:0]  stk_rd_row;
  logic [CW-1:0]  stk_rd_col;
  logic [gmps_pkg::MOVE_W-1:0] stk_rd_move;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= gmps_pkg::CFG_DATA_W'(16);
      cols_cfg <= gmps_pkg::CFG_DATA_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gmps_pkg::REG_ROWS: rows_cfg <= cfg_data;
        gmps_pkg::REG_COLS: cols_cfg <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp rows and cols to the supported range
  always_comb begin
    if (rows_cfg == '0) begin
      nr = NRW'(1);
    end else if (int'(rows_cfg) > MAX_ROWS) begin
      nr = NRW'(MAX_ROWS);
    end else begin
      nr = NRW'(rows_cfg);
    end
    if (cols_cfg == '0) begin
      nc = NCW'(1);
    end else if (int'(cols_cfg) > MAX_COLS) begin
      nc = NCW'(MAX_COLS);
    end else begin
      nc = NCW'(cols_cfg);
    end
    for (int c = 0; c < MAX_COLS; c++) begin
      colmask[c] = (c < int'(nc));
    end
  end

  // Row load position
  always_comb begin
    load_idx  = (int'(load_cnt) >= MAX_ROWS) ? NRW'(MAX_ROWS - 1) : load_cnt;
    load_inc  = load_idx + 1'b1;
    load_done = (load_inc >= nr);
  end

  // Neighbor for the current move
  always_comb begin
    nb_r  = cur_r;
    nb_c  = cur_c;
    nb_ok = 1'b0;
    case (cur_mv)
      gmps_pkg::MOVE_DOWN: begin
        nb_r  = cur_r + 1'b1;
        nb_ok = (({1'b0, cur_r} + 1'b1) < nr);
      end
      gmps_pkg::MOVE_RIGHT: begin
        nb_c  = cur_c + 1'b1;
        nb_ok = (({1'b0, cur_c} + 1'b1) < nc);
      end
      gmps_pkg::MOVE_LEFT: begin
        nb_c  = cur_c - 1'b1;
        nb_ok = (cur_c != '0);
      end
      gmps_pkg::MOVE_UP: begin
        nb_r  = cur_r - 1'b1;
        nb_ok = (cur_r != '0);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  // Shared neighbor check and step decode
  always_comb begin
    visit_addr = (state == ST_COPY) ? copy_idx : nb_r;
    visit_rd   = visit_rows[visit_addr];
    wall_rd    = wall_rows[nb_r];
    blocked    = wall_rd[nb_c] || visit_rd[nb_c];
    depth_m1   = depth - 1'b1;
    depth_m2   = depth - 2'd2;
    at_target  = ({1'b0, cur_r} == nr - 1'b1) && ({1'b0, cur_c} == nc - 1'b1);
    pop        = (state == ST_SEARCH) && (cur_mv == gmps_pkg::MOVE_DONE);
    pop_last   = pop && (depth == DEP_W'(1));
    push       = (state == ST_SEARCH) && !(at_target && cur_mv == gmps_pkg::MOVE_DOWN)
                 && (cur_mv != gmps_pkg::MOVE_DONE) && nb_ok && !blocked
                 && (int'(depth) < STK_N);
    stk_cmd.wr_en = push;
    stk_cmd.rd_en = pop && !pop_last;
  end

  gmps_stack #(
    .ROW_W  (RW),
    .COL_W  (CW),
    .DEPTH  (STK_N),
    .ADDR_W (SAW)
  ) u_stack (
    .clk     (clk),
    .cmd     (stk_cmd),
    .wr_addr (depth_m1[SAW-1:0]),
    .wr_row  (cur_r),
    .wr_col  (cur_c),
    .wr_move (cur_mv + 1'b1),
    .rd_addr (depth_m2[SAW-1:0]),
    .rd_row  (stk_rd_row),
    .rd_col  (stk_rd_col),
    .rd_move (stk_rd_move)
  );

  // Store incoming wall rows
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      wall_rows[load_idx[RW-1:0]] <= MAX_COLS'(row_walls);
    end
  end

  // Visit marks: start cell on launch, mark on advance, clear on backtrack
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MAX_ROWS; r++) begin
        visit_rows[r] <= '0;
      end
    end else begin
      if (in_xfer && load_done) begin
        visit_rows[0][0] <= 1'b1;
      end
      if (push) begin
        visit_rows[nb_r][nb_c] <= 1'b1;
      end
      if (pop && !pop_last) begin
        visit_rows[cur_r][cur_c] <= 1'b0;
      end
    end
  end

  // Copy the current path into the answer
  always_ff @(posedge clk) begin
    if (state == ST_COPY) begin
      answer_rows[copy_idx] <= visit_rd;
    end
  end

  // Sequencer: load, search, copy, reload top of stack, send answer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      load_cnt  <= '0;
      depth     <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
      cur_r     <= '0;
      cur_c     <= '0;
      cur_mv    <= gmps_pkg::MOVE_DOWN;
      copy_idx  <= '0;
      out_idx   <= '0;
    end else begin
      // Drop a taken answer row; the answer state refills or holds it itself
      if (out_ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (load_done) begin
              load_cnt <= '0;
              cur_r    <= '0;
              cur_c    <= '0;
              cur_mv   <= gmps_pkg::MOVE_DOWN;
              depth    <= DEP_W'(1);
              found    <= 1'b0;
              state    <= ST_SEARCH;
            end else begin
              load_cnt <= load_inc;
            end
          end
        end
        ST_SEARCH: begin
          if (at_target && cur_mv == gmps_pkg::MOVE_DOWN) begin
            copy_idx <= '0;
            state    <= ST_COPY;
          end else if (pop) begin
            depth <= depth_m1;
            if (pop_last) begin
              out_idx <= '0;
              state   <= ST_OUT;
            end else begin
              state <= ST_POPLD;
            end
          end else if (push) begin
            cur_r  <= nb_r;
            cur_c  <= nb_c;
            cur_mv <= gmps_pkg::MOVE_DOWN;
            depth  <= depth + 1'b1;
          end else begin
            cur_mv <= cur_mv + 1'b1;
          end
        end
        ST_COPY: begin
          copy_idx <= copy_idx + 1'b1;
          if ({1'b0, copy_idx} == nr - 1'b1) begin
            found  <= 1'b1;
            cur_mv <= gmps_pkg::MOVE_DONE;
            state  <= ST_SEARCH;
          end
        end
        ST_POPLD: begin
          cur_r  <= stk_rd_row;
          cur_c  <= stk_rd_col;
          cur_mv <= stk_rd_move;
          state  <= ST_SEARCH;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_idx   <= out_idx + 1'b1;
            if ({1'b0, out_idx} == nr - 1'b1) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      path_row <= found ? gmps_pkg::FIELD_W'(answer_rows[out_idx] & colmask) : '0;
      last_row <= ({1'b0, out_idx} == nr - 1'b1);
    end
  end

  // Stack depth stays within the cell count
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    int'(depth) <= STK_N)
    else $error("stack depth above cell count");

  // The start cell stays marked for the whole search
  a_start_marked: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> visit_rows[0][0])
    else $error("start cell lost its mark during search");

  // A search always holds at least one level
  a_search_depth: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH || state == ST_COPY || state == ST_POPLD) |-> (depth != '0))
    else $error("search running with empty stack");

  // Leaving the search empties the stack
  a_out_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> (depth == '0))
    else $error("answer sent with search levels left");

endmodule

`default_nettype wire
